>>> hw/rtl/btct_pkg.sv
// ----------------------------------------------------------------------------
// btct_pkg
// Shared types and codes for the complement-take binary trie store.
// ----------------------------------------------------------------------------
package btct_pkg;

   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // request modes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_TAKE   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // controller status toward the request/response ports
   typedef struct packed {
      logic       idle;
      logic       done;
      logic [1:0] status;
   } ctrl_stat_type;

endpackage

>>> hw/rtl/btct_node_mem.sv
// ----------------------------------------------------------------------------
// btct_node_mem
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btct_node_mem #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 48,
   parameter int DEPTH  = 65536
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] node_ram [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_ram[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/btct_ctrl.sv
// ----------------------------------------------------------------------------
// btct_ctrl
// Trie walk sequencer: insert (scan, room check, allocate walk), take
// (preferred/fallback child walk with count decrement) and clear.
// ----------------------------------------------------------------------------
module btct_ctrl #(
   parameter int KEY_BITS   = 30,
   parameter int NODE_SLOTS = 65536,
   parameter int NODE_W     = 16,
   parameter int ENTRY_W    = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                start_mode,
   input  logic [KEY_BITS-1:0]       start_key,
   input  logic                      out_ready,
   output btct_pkg::ctrl_stat_type   stat,
   output logic [KEY_BITS-1:0]       taken_value,
   output logic                      rd_en,
   output logic [NODE_W-1:0]         rd_addr,
   input  logic [ENTRY_W-1:0]        rd_data,
   output logic                      wr_en,
   output logic [NODE_W-1:0]         wr_addr,
   output logic [ENTRY_W-1:0]        wr_data
);

   import btct_pkg::*;

   localparam int LVL_W = $clog2(KEY_BITS + 1);
   localparam int SUM_W = NODE_W + 2;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN    = 7'b0000010,
      S_CHECK   = 7'b0000100,
      S_INS     = 7'b0001000,
      S_TK_PREF = 7'b0010000,
      S_TK_TEST = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   key_sh_ff, key_sh_in;
   logic [KEY_BITS-1:0]   val_ff, val_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [LVL_W-1:0]      need_ff, need_in;
   logic [NODE_W-1:0]     idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [NODE_W-1:0]     pref_ff, pref_in;
   logic [NODE_W-1:0]     oth_ff, oth_in;
   logic                  pb_ff, pb_in;
   logic [NODE_W-1:0]     root0_ff, root0_in;
   logic [NODE_W-1:0]     root1_ff, root1_in;
   logic [NODE_W:0]       free_ff, free_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [1:0]            status_ff, status_in;

   logic [NODE_W-1:0]     rd_zero, rd_one;
   logic [COUNT_W-1:0]    rd_cnt, cnt_dec;
   logic [NODE_W-1:0]     cur_zero, cur_one;
   logic [COUNT_W-1:0]    cur_cnt;
   logic                  kb;
   logic [NODE_W-1:0]     c_sel, c_pref, c_oth, new_node;
   logic                  lvl_done;
   logic [KEY_BITS-1:0]   val_shift;
   logic [SUM_W-1:0]      room_sum;

   assign rd_zero = rd_data[ENTRY_W-1 -: NODE_W];
   assign rd_one  = rd_data[COUNT_W +: NODE_W];
   assign rd_cnt  = rd_data[COUNT_W-1:0];
   assign cnt_dec = rd_cnt - COUNT_W'(rd_cnt != '0);

   // current node: root registers, pending read data, or a fresh node
   always_comb begin
      if (idx_ff == '0) begin
         cur_zero = root0_ff;
         cur_one  = root1_ff;
         cur_cnt  = '0;
      end else if (pend_ff) begin
         cur_zero = rd_zero;
         cur_one  = rd_one;
         cur_cnt  = rd_cnt;
      end else begin
         cur_zero = '0;
         cur_one  = '0;
         cur_cnt  = '0;
      end
   end

   assign kb        = key_sh_ff[0];
   assign c_sel     = kb ? cur_one : cur_zero;
   assign c_pref    = kb ? cur_zero : cur_one;
   assign c_oth     = kb ? cur_one : cur_zero;
   assign new_node  = free_ff[NODE_W-1:0];
   assign lvl_done  = (lvl_ff == LVL_W'(KEY_BITS));
   assign val_shift = val_ff >> 1;
   assign room_sum  = SUM_W'(free_ff) + SUM_W'(need_ff);

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      key_sh_in = key_sh_ff;
      val_in    = val_ff;
      lvl_in    = lvl_ff;
      need_in   = need_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      pref_in   = pref_ff;
      oth_in    = oth_ff;
      pb_in     = pb_ff;
      root0_in  = root0_ff;
      root1_in  = root1_ff;
      free_in   = free_ff;
      total_in  = total_ff;
      status_in = status_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in    = start_key;
               key_sh_in = start_key;
               val_in    = '0;
               lvl_in    = '0;
               idx_in    = '0;
               pend_in   = 1'b0;
               status_in = STAT_OK;
               state_in  = S_DONE;
               case (start_mode)
                  MODE_INSERT: state_in = S_SCAN;
                  MODE_TAKE: begin
                     if (total_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = S_TK_PREF;
                     end
                  end
                  MODE_CLEAR: begin
                     root0_in = '0;
                     root1_in = '0;
                     free_in  = (NODE_W+1)'(1);
                     total_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         // follow the existing path to find how many nodes are missing
         S_SCAN: begin
            if (lvl_done) begin
               need_in  = '0;
               state_in = S_CHECK;
            end else if (c_sel == '0) begin
               need_in  = LVL_W'(KEY_BITS) - lvl_ff;
               state_in = S_CHECK;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = c_sel;
               idx_in    = c_sel;
               pend_in   = 1'b1;
               key_sh_in = key_sh_ff >> 1;
               lvl_in    = lvl_ff + LVL_W'(1);
            end
         end

         S_CHECK: begin
            if (total_ff == COUNT_MAX || room_sum > SUM_W'(NODE_SLOTS)) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               idx_in    = '0;
               pend_in   = 1'b0;
               lvl_in    = '0;
               key_sh_in = key_ff;
               state_in  = S_INS;
            end
         end

         // write back each node with its count bumped, allocating as needed
         S_INS: begin
            if (lvl_done) begin
               wr_en     = 1'b1;
               wr_data   = {cur_zero, cur_one, cur_cnt + COUNT_W'(1)};
               total_in  = total_ff + COUNT_W'(1);
               state_in  = S_DONE;
            end else begin
               key_sh_in = key_sh_ff >> 1;
               lvl_in    = lvl_ff + LVL_W'(1);
               if (c_sel != '0) begin
                  wr_en   = (idx_ff != '0);
                  wr_data = {cur_zero, cur_one, cur_cnt + COUNT_W'(1)};
                  rd_en   = 1'b1;
                  rd_addr = c_sel;
                  idx_in  = c_sel;
                  pend_in = 1'b1;
               end else begin
                  free_in = free_ff + (NODE_W+1)'(1);
                  idx_in  = new_node;
                  pend_in = 1'b0;
                  if (idx_ff == '0) begin
                     if (kb) root1_in = new_node;
                     else    root0_in = new_node;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = kb ? {cur_zero, new_node, cur_cnt + COUNT_W'(1)}
                                  : {new_node, cur_one, cur_cnt + COUNT_W'(1)};
                  end
               end
            end
         end

         // rd_data holds the node chosen one level up; retire its count here
         S_TK_PREF: begin
            if (idx_ff != '0) begin
               wr_en   = 1'b1;
               wr_data = {rd_zero, rd_one, cnt_dec};
            end
            if (lvl_done) begin
               total_in = total_ff - COUNT_W'(1);
               state_in = S_DONE;
            end else if (c_pref != '0) begin
               rd_en    = 1'b1;
               rd_addr  = c_pref;
               pref_in  = c_pref;
               oth_in   = c_oth;
               pb_in    = ~kb;
               state_in = S_TK_TEST;
            end else begin
               // no preferred child: fall back to the key's own bit
               rd_en     = (c_oth != '0);
               rd_addr   = c_oth;
               idx_in    = c_oth;
               pend_in   = 1'b1;
               val_in    = val_shift;
               val_in[KEY_BITS-1] = kb;
               key_sh_in = key_sh_ff >> 1;
               lvl_in    = lvl_ff + LVL_W'(1);
            end
         end

         S_TK_TEST: begin
            key_sh_in = key_sh_ff >> 1;
            lvl_in    = lvl_ff + LVL_W'(1);
            val_in    = val_shift;
            pend_in   = 1'b1;
            state_in  = S_TK_PREF;
            if (rd_cnt != '0) begin
               idx_in = pref_ff;
               val_in[KEY_BITS-1] = pb_ff;
            end else begin
               rd_en   = (oth_ff != '0);
               rd_addr = oth_ff;
               idx_in  = oth_ff;
               val_in[KEY_BITS-1] = ~pb_ff;
            end
         end

         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         root0_ff  <= '0;
         root1_ff  <= '0;
         free_ff   <= (NODE_W+1)'(1);
         total_ff  <= '0;
         pend_ff   <= 1'b0;
         idx_ff    <= '0;
         lvl_ff    <= '0;
         status_ff <= STAT_OK;
      end else begin
         state_ff  <= state_in;
         root0_ff  <= root0_in;
         root1_ff  <= root1_in;
         free_ff   <= free_in;
         total_ff  <= total_in;
         pend_ff   <= pend_in;
         idx_ff    <= idx_in;
         lvl_ff    <= lvl_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      key_sh_ff <= key_sh_in;
      val_ff    <= val_in;
      need_ff   <= need_in;
      pref_ff   <= pref_in;
      oth_ff    <= oth_in;
      pb_ff     <= pb_in;
   end

   assign stat.idle   = (state_ff == S_IDLE);
   assign stat.done   = (state_ff == S_DONE);
   assign stat.status = status_ff;
   assign taken_value = val_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= (NODE_W+1)'(NODE_SLOTS))
      else $error("node allocator ran past the table");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write hit the same node in one cycle");

   a_root_in_regs: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != '0))
      else $error("root node written to the table");

   a_take_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TK_PREF && lvl_done) |=> (total_ff == $past(total_ff) - COUNT_W'(1)))
      else $error("stored total not decremented on take");

endmodule

>>> hw/rtl/bitwise_trie_complement_take.sv
// ----------------------------------------------------------------------------
// bitwise_trie_complement_take
// Binary trie multiset of keys with insert, complement-preferring take and
// clear; nodes live in a single-port-read table, root links in registers.
// ----------------------------------------------------------------------------
// Walks: one trie level per cycle on the insert scan and allocate walks; take
//   adds a preferred-child test state on levels with a preferred child, as the
//   node table has a single read port.
// Throughput: one request in flight; the next is taken once the response is
//   in the output register. Clear, mode 3 and an empty take go straight to done.
// Reset: synchronous; empties the store at once (root links and counters).
module bitwise_trie_complement_take #(
   parameter int KEY_BITS   = 30,
   parameter int NODE_SLOTS = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KEY_BITS-1:0] rsp_taken_value,
   output logic [1:0]          rsp_status
);

   import btct_pkg::*;

   localparam int NODE_W  = $clog2(NODE_SLOTS);
   localparam int ENTRY_W = 2 * NODE_W + COUNT_W;

   ctrl_stat_type        stat;
   logic [KEY_BITS-1:0]  taken_value;
   logic                 out_ready, load;
   logic                 rd_en, wr_en;
   logic [NODE_W-1:0]    rd_addr, wr_addr;
   logic [ENTRY_W-1:0]   rd_data, wr_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]  rsp_value_ff;
   logic [1:0]           rsp_status_ff;

   assign req_stall = ~stat.idle;
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;
   assign load      = stat.done & out_ready;

   btct_ctrl #(
      .KEY_BITS   (KEY_BITS),
      .NODE_SLOTS (NODE_SLOTS),
      .NODE_W     (NODE_W),
      .ENTRY_W    (ENTRY_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid & stat.idle),
      .start_mode  (req_mode),
      .start_key   (req_key),
      .out_ready   (out_ready),
      .stat        (stat),
      .taken_value (taken_value),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   btct_node_mem #(
      .ADDR_W (NODE_W),
      .DATA_W (ENTRY_W),
      .DEPTH  (NODE_SLOTS)
   ) u_node_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff  <= taken_value;
         rsp_status_ff <= stat.status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
